// ----- src/mcit_pkg.sv -----
// Shared types and constants for the multi-channel interval timer bank.
// No dependencies; imported by multi_channel_interval_timer_top.
package mcit_pkg;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_SET_ACTIVE = 3'd2,
    OP_START      = 3'd3,
    OP_STOP       = 3'd4,
    OP_TICK       = 3'd5
  } op_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam int CHANNEL_W    = 4;
  localparam int MAX_RESULTS  = 16;
  localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

endpackage

// ----- src/multi_channel_interval_timer_top.sv -----
// Multi-channel interval timer bank: membership/enable flags in flops, counts and
// periods in single-port-write memories, scanned by one shared increment/compare.
// Depends on mcit_pkg.

// Usage: a command word is taken when start is high and busy is low. Add, remove,
// set_active, stop and unused codes return their status word on the next cycle and
// busy stays low. Start from the stopped state returns its status on the next cycle,
// then holds busy while the count memory is zeroed one entry per cycle. A tick while
// running holds busy for one pass over the count memory read port, with the increment
// and period compare one entry behind the read. Expiry words come out in channel
// order, one per cycle at most; each is held until the next expiring channel is
// visited or the pass ends, so the final one, which carries last, shows in the first
// cycle after busy drops. Every result is shown for exactly one cycle with strobe
// high, and the receiver cannot hold it off.
module multi_channel_interval_timer_top
  import mcit_pkg::*;
#(
  parameter int CHANNELS    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           operation,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [15:0]          interval_ticks,
  input  logic                 one_shot,
  input  logic                 enable,
  output logic                 strobe,
  output logic                 kind,
  output logic [CHANNEL_W-1:0] channel_out,
  output logic                 ok,
  output logic                 last
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(CHANNELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN
  } state_t;

  state_t                  state;
  logic [CW-1:0]           cnt;
  logic                    s1_valid;
  logic [AW-1:0]           s1_idx;
  logic                    pend_valid;
  logic [CHANNEL_W-1:0]    pend_ch;
  logic [RESULT_CNT_W-1:0] n_rep;
  logic                    running;
  logic [CHANNELS-1:0]     member;
  logic [CHANNELS-1:0]     enabled;
  logic [CHANNELS-1:0]     single_shot;

  logic [COUNT_WIDTH-1:0]  count_mem  [CHANNELS];
  logic [COUNT_WIDTH-1:0]  period_mem [CHANNELS];
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [COUNT_WIDTH-1:0]  period_q;

  op_t                     op_in;
  logic                    accept;
  logic                    in_bank;
  logic [AW-1:0]           ci;
  logic                    add_ok;
  logic                    rem_ok;
  logic                    set_ok;
  logic                    s1_active;
  logic [COUNT_WIDTH-1:0]  count_inc;
  logic                    s1_hit;
  logic                    scan_end;
  logic [AW-1:0]           rd_addr;

  logic                    cnt_we;
  logic [AW-1:0]           cnt_waddr;
  logic [COUNT_WIDTH-1:0]  cnt_wdata;
  logic                    per_we;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    op_in     = op_t'(operation);
    in_bank   = ({3'b000, channel} < 7'(CHANNELS));
    ci        = AW'(channel);
    add_ok    = in_bank && !running && !member[ci];
    rem_ok    = in_bank && !running && member[ci];
    set_ok    = in_bank && member[ci];
    s1_active = member[s1_idx] && enabled[s1_idx];
    count_inc = count_q + COUNT_WIDTH'(1);
    s1_hit    = (count_inc == period_q);
    scan_end  = (cnt == CW'(CHANNELS)) && !s1_valid;
    rd_addr   = cnt[AW-1:0];
  end

  // Count memory write port: add, set_active from disabled, start sweep, tick update
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = ci;
    cnt_wdata = '0;
    per_we    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && op_in == OP_ADD && add_ok) begin
          cnt_we = 1'b1;
          per_we = 1'b1;
        end else if (accept && op_in == OP_SET_ACTIVE && set_ok && !enabled[ci]) begin
          cnt_we = 1'b1;
        end
      end
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cnt[AW-1:0];
      end
      S_SCAN: begin
        cnt_we    = s1_valid && s1_active;
        cnt_waddr = s1_idx;
        cnt_wdata = s1_hit ? '0 : count_inc;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    if (per_we) begin
      period_mem[ci] <= COUNT_WIDTH'(interval_ticks);
    end
    count_q  <= count_mem[rd_addr];
    period_q <= period_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      s1_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      n_rep       <= '0;
      running     <= 1'b0;
      member      <= '0;
      enabled     <= '0;
      single_shot <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind        <= KIND_STATUS;
            last        <= 1'b1;
            channel_out <= channel;
            unique case (op_in)
              OP_ADD: begin
                strobe <= 1'b1;
                ok     <= add_ok;
                if (add_ok) begin
                  member[ci]      <= 1'b1;
                  enabled[ci]     <= 1'b0;
                  single_shot[ci] <= one_shot;
                end
              end
              OP_REMOVE: begin
                strobe <= 1'b1;
                ok     <= rem_ok;
                if (rem_ok) begin
                  member[ci]  <= 1'b0;
                  enabled[ci] <= 1'b0;
                end
              end
              OP_SET_ACTIVE: begin
                strobe <= 1'b1;
                ok     <= set_ok;
                if (set_ok) begin
                  enabled[ci] <= enable;
                end
              end
              OP_START: begin
                strobe      <= 1'b1;
                ok          <= 1'b1;
                channel_out <= '0;
                if (!running) begin
                  running <= 1'b1;
                  cnt     <= '0;
                  state   <= S_CLEAR;
                end
              end
              OP_STOP: begin
                strobe      <= 1'b1;
                ok          <= 1'b1;
                channel_out <= '0;
                running     <= 1'b0;
              end
              OP_TICK: begin
                // Ticks while stopped are dropped without a result
                if (running) begin
                  cnt        <= '0;
                  s1_valid   <= 1'b0;
                  pend_valid <= 1'b0;
                  n_rep      <= '0;
                  state      <= S_SCAN;
                end
              end
              default: begin
                strobe <= 1'b1;
                ok     <= 1'b0;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (cnt == CW'(CHANNELS - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SCAN: begin
          // Issue the next read while the previous entry is updated
          if (cnt != CW'(CHANNELS)) begin
            s1_valid <= 1'b1;
            s1_idx   <= cnt[AW-1:0];
            cnt      <= cnt + CW'(1);
          end else begin
            s1_valid <= 1'b0;
          end
          if (s1_valid && s1_active && s1_hit) begin
            if (single_shot[s1_idx]) begin
              enabled[s1_idx] <= 1'b0;
            end
            // Hold each expiry until the next one or the end of the pass so the final one can carry last
            if (n_rep < RESULT_CNT_W'(MAX_RESULTS)) begin
              n_rep      <= n_rep + RESULT_CNT_W'(1);
              pend_valid <= 1'b1;
              pend_ch    <= CHANNEL_W'(s1_idx);
              if (pend_valid) begin
                strobe      <= 1'b1;
                kind        <= KIND_EXPIRY;
                channel_out <= pend_ch;
                ok          <= 1'b1;
                last        <= 1'b0;
              end
            end
          end
          if (scan_end) begin
            if (pend_valid) begin
              strobe      <= 1'b1;
              kind        <= KIND_EXPIRY;
              channel_out <= pend_ch;
              ok          <= 1'b1;
              last        <= 1'b1;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_EXPIRY |-> ok)
    else $error("expiry reported without ok");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_STATUS |-> last)
    else $error("status word not marked last");

  a_stopped_tick_silent: assert property (@(posedge clk) disable iff (rst)
    accept && op_in == OP_TICK && !running |=> !strobe && !busy)
    else $error("tick while stopped produced activity");

  a_last_expiry_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_EXPIRY && last |-> !busy)
    else $error("block still busy after final expiry");

  a_report_limit: assert property (@(posedge clk) disable iff (rst)
    n_rep <= RESULT_CNT_W'(MAX_RESULTS))
    else $error("expiry report count over limit");
`endif

endmodule
